// File: hdl/q2e_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: shared package
// Widths, the arctangent table and the per-step functions of the pipeline.
// ----------------------------------------------------------------------------
package q2e_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int TABLE_LEN     = 24;
	localparam int VW            = 38;
	localparam int AW            = 32;
	localparam int NORM_BIT      = 33;
	localparam int SQ_PAIRS      = 29;
	localparam int SQ_PER        = 4;
	localparam int SQ_STG        = (SQ_PAIRS + SQ_PER - 1) / SQ_PER;

	localparam logic [15:0]        THR_RESET = 16'd32;
	localparam logic signed [34:0] ONE_Q28   = 35'sd268435456;
	localparam logic [AW-1:0]      ACC_PI    = 32'h8000_0000;
	localparam logic signed [15:0] QUARTER   = 16'sd16384;

	localparam logic [AW-1:0] ATAN_TAB [TABLE_LEN] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef struct packed {
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic [VW-1:0]        m;
		logic [AW-1:0]        acc;
		logic                 zero;
	} cvec_t;

	typedef struct packed {
		cvec_t vx;
		cvec_t vy;
		cvec_t vz;
		logic  dx;
		logic  dz;
		logic  sat;
		logic  s_pos;
	} item_t;

	typedef struct packed {
		item_t                   it;
		logic [2*SQ_PAIRS-1:0]   rad;
		logic [31:0]             rem;
		logic [SQ_PAIRS-1:0]     root;
	} sqrt_t;

	// Folds the vector into the right half plane and records its magnitude bound.
	function automatic cvec_t prep_vec(cvec_t v);
		cvec_t r;
		logic signed [VW-1:0] ay;
		r = v;
		r.zero = (v.x == '0) && (v.y == '0);
		r.acc = '0;
		if (v.x < 0) begin
			r.x = -v.x;
			r.y = -v.y;
			r.acc = ACC_PI;
		end
		ay = (r.y < 0) ? -r.y : r.y;
		r.m = r.x | ay;
		return r;
	endfunction

	// Shifts left by sh when the magnitude stays below the normalising limit.
	function automatic cvec_t norm_step(cvec_t v, int sh, int lim);
		cvec_t r;
		r = v;
		if ((v.m >> lim) == '0) begin
			r.x = v.x <<< sh;
			r.y = v.y <<< sh;
			r.m = v.m << sh;
		end
		return r;
	endfunction

	function automatic cvec_t cordic_step(cvec_t v, int i);
		cvec_t r;
		logic signed [VW-1:0] xs;
		logic signed [VW-1:0] ys;
		r = v;
		xs = v.x >>> i;
		ys = v.y >>> i;
		if (!v.y[VW-1]) begin
			r.x = v.x + ys;
			r.y = v.y - xs;
			r.acc = v.acc + ATAN_TAB[i];
		end else begin
			r.x = v.x - ys;
			r.y = v.y + xs;
			r.acc = v.acc - ATAN_TAB[i];
		end
		return r;
	endfunction

	// One result bit of the integer square root.
	function automatic sqrt_t sqrt_step(sqrt_t q);
		sqrt_t r;
		logic [33:0] tmp;
		logic [33:0] trial;
		r = q;
		tmp = {q.rem, q.rad[2*SQ_PAIRS-1 -: 2]};
		trial = {3'b000, q.root, 2'b01};
		if (tmp >= trial) begin
			r.rem = 32'(tmp - trial);
			r.root = {q.root[SQ_PAIRS-2:0], 1'b1};
		end else begin
			r.rem = tmp[31:0];
			r.root = {q.root[SQ_PAIRS-2:0], 1'b0};
		end
		r.rad = q.rad << 2;
		return r;
	endfunction

	function automatic logic [15:0] to16(logic [AW-1:0] acc);
		logic [AW-1:0] s;
		s = acc + 32'h0000_8000;
		return s[AW-1:16];
	endfunction

endpackage

// File: hdl/quaternion_to_euler_angles_top.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles
// Products, square root, normalisation and three CORDIC vectoring pipelines.
// ----------------------------------------------------------------------------
// Stages in order: products, sums, degenerate tests, square root, fold, normalisation, CORDIC, result.
// Throughput: one quaternion per cycle; the whole pipeline holds while a
// finished result waits at the output register.
// Reset: arst_n clears all valid bits and loads degenerate_threshold with 32.
module quaternion_to_euler_angles_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,      // degenerate_threshold
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // quat_w, quat_x, quat_y, quat_z
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // angle_about_x, angle_about_y, angle_about_z
);

	localparam int NS = q2e_pkg::SQ_STG;
	localparam int NC = q2e_pkg::CORDIC_STAGES;

	logic en;
	logic [15:0] thr_q;

	logic signed [15:0] qw, qx, qy, qz;
	logic signed [31:0] ww_s1, xx_s1, yy_s1, zz_s1, yz_s1, wx_s1, xz_s1, wy_s1, xy_s1, wz_s1;
	logic signed [15:0] w_s1, x_s1;
	logic vld_s1;

	logic signed [34:0] nx_s2, dnx_s2, nz_s2, dnz_s2, s_s2;
	logic signed [15:0] w_s2, x_s2;
	logic vld_s2;
	logic signed [34:0] nx_c, dnx_c, nz_c, dnz_c, d_c, sr_c;

	q2e_pkg::sqrt_t sq_s3, sq_c;
	logic vld_s3;
	logic [34:0] anx, adnx, anz, adnz, thr_w;
	logic signed [29:0] s_n;
	logic signed [59:0] ssq;
	logic dgx, dgz;

	q2e_pkg::sqrt_t sqr_s4 [NS];
	q2e_pkg::sqrt_t sqr_in [NS];
	logic [NS-1:0] sqr_vld_s4;

	q2e_pkg::item_t prep_s5, prep_c;
	q2e_pkg::item_t nrm_s6, nrm_s7, n1_c, n2_c;
	logic vld_s5, vld_s6, vld_s7;

	q2e_pkg::item_t cord_s8 [NC];
	q2e_pkg::item_t cord_in [NC];
	logic [NC-1:0] cord_vld_s8;

	q2e_pkg::item_t fin;
	logic [q2e_pkg::AW-1:0] ax_acc, ay_acc, az_acc;
	logic signed [15:0] ox, oy, oz, ty;
	logic res_vld_s9;

	assign en            = !res_vld_s9 || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = res_vld_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= q2e_pkg::THR_RESET;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	assign qw = s_axis_tdata[15:0];
	assign qx = s_axis_tdata[31:16];
	assign qy = s_axis_tdata[47:32];
	assign qz = s_axis_tdata[63:48];

	// Stage 1: the ten products.
	always_ff @(posedge clk) begin
		if (en) begin
			ww_s1 <= qw * qw;
			xx_s1 <= qx * qx;
			yy_s1 <= qy * qy;
			zz_s1 <= qz * qz;
			yz_s1 <= qy * qz;
			wx_s1 <= qw * qx;
			xz_s1 <= qx * qz;
			wy_s1 <= qw * qy;
			xy_s1 <= qx * qy;
			wz_s1 <= qw * qz;
			w_s1  <= qw;
			x_s1  <= qx;
		end
	end

	// Stage 2: sums and the clamped sine argument.
	always_comb begin
		nx_c  = (35'(yz_s1) + 35'(wx_s1)) <<< 1;
		dnx_c = 35'(ww_s1) - 35'(xx_s1) - 35'(yy_s1) + 35'(zz_s1);
		nz_c  = (35'(xy_s1) + 35'(wz_s1)) <<< 1;
		dnz_c = 35'(ww_s1) + 35'(xx_s1) - 35'(yy_s1) - 35'(zz_s1);
		d_c   = 35'(xz_s1) - 35'(wy_s1);
		sr_c  = -(d_c <<< 1);
		if (sr_c > q2e_pkg::ONE_Q28) begin
			sr_c = q2e_pkg::ONE_Q28;
		end else if (sr_c < -q2e_pkg::ONE_Q28) begin
			sr_c = -q2e_pkg::ONE_Q28;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s2  <= nx_c;
			dnx_s2 <= dnx_c;
			nz_s2  <= nz_c;
			dnz_s2 <= dnz_c;
			s_s2   <= sr_c;
			w_s2   <= w_s1;
			x_s2   <= x_s1;
		end
	end

	// Stage 3: degenerate tests, source selection and the square of the sine.
	// The clamped sine lies within plus or minus 2^28, so 30 bits hold it.
	always_comb begin
		thr_w = 35'(thr_q);
		anx   = (nx_s2 < 0) ? 35'(-nx_s2) : 35'(nx_s2);
		adnx  = (dnx_s2 < 0) ? 35'(-dnx_s2) : 35'(dnx_s2);
		anz   = (nz_s2 < 0) ? 35'(-nz_s2) : 35'(nz_s2);
		adnz  = (dnz_s2 < 0) ? 35'(-dnz_s2) : 35'(dnz_s2);
		dgx   = (anx <= thr_w) && (adnx <= thr_w);
		dgz   = (anz <= thr_w) && (adnz <= thr_w);
		s_n   = s_s2[29:0];
		ssq   = s_n * s_n;
		sq_c  = '0;
		if (dgx) begin
			sq_c.it.vx.x = q2e_pkg::VW'(w_s2);
			sq_c.it.vx.y = q2e_pkg::VW'(x_s2);
		end else begin
			sq_c.it.vx.x = q2e_pkg::VW'(dnx_s2);
			sq_c.it.vx.y = q2e_pkg::VW'(nx_s2);
		end
		sq_c.it.vz.x  = q2e_pkg::VW'(dnz_s2);
		sq_c.it.vz.y  = q2e_pkg::VW'(nz_s2);
		sq_c.it.vy.y  = q2e_pkg::VW'(s_s2);
		sq_c.it.dx    = dgx;
		sq_c.it.dz    = dgz;
		sq_c.it.s_pos = (s_s2 > 0);
		sq_c.rad      = {1'b0, (57'd1 << 56) - ssq[56:0]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3 <= sq_c;
		end
	end

	// Square root, SQ_PER result bits a stage and fewer in the last, SQ_PAIRS in all.
	for (genvar g = 0; g < NS; g++) begin : g_sqrt
		q2e_pkg::sqrt_t nxt;
		if (g == 0) begin : g_first
			assign sqr_in[g] = sq_s3;
		end else begin : g_next
			assign sqr_in[g] = sqr_s4[g-1];
		end
		always_comb begin
			nxt = sqr_in[g];
			for (int j = 0; j < q2e_pkg::SQ_PER; j++) begin
				if (g * q2e_pkg::SQ_PER + j < q2e_pkg::SQ_PAIRS) begin
					nxt = q2e_pkg::sqrt_step(nxt);
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sqr_s4[g] <= nxt;
			end
		end
	end

	// Take the root as the cosine, flag saturation and fold into the right half plane.
	always_comb begin
		prep_c      = sqr_s4[NS-1].it;
		prep_c.vy.x = q2e_pkg::VW'(sqr_s4[NS-1].root);
		prep_c.sat  = (sqr_s4[NS-1].root == '0);
		prep_c.vx   = q2e_pkg::prep_vec(prep_c.vx);
		prep_c.vy   = q2e_pkg::prep_vec(prep_c.vy);
		prep_c.vz   = q2e_pkg::prep_vec(prep_c.vz);
	end

	// Normalisation in two stages of binary shift steps.
	always_comb begin
		n1_c    = prep_s5;
		n1_c.vx = q2e_pkg::norm_step(q2e_pkg::norm_step(q2e_pkg::norm_step(
			q2e_pkg::norm_step(prep_s5.vx, 32, 1), 16, 17), 8, 25), 4, 29);
		n1_c.vy = q2e_pkg::norm_step(q2e_pkg::norm_step(q2e_pkg::norm_step(
			q2e_pkg::norm_step(prep_s5.vy, 32, 1), 16, 17), 8, 25), 4, 29);
		n1_c.vz = q2e_pkg::norm_step(q2e_pkg::norm_step(q2e_pkg::norm_step(
			q2e_pkg::norm_step(prep_s5.vz, 32, 1), 16, 17), 8, 25), 4, 29);
		n2_c    = nrm_s6;
		n2_c.vx = q2e_pkg::norm_step(q2e_pkg::norm_step(q2e_pkg::norm_step(
			nrm_s6.vx, 2, 31), 1, 32), 1, q2e_pkg::NORM_BIT);
		n2_c.vy = q2e_pkg::norm_step(q2e_pkg::norm_step(q2e_pkg::norm_step(
			nrm_s6.vy, 2, 31), 1, 32), 1, q2e_pkg::NORM_BIT);
		n2_c.vz = q2e_pkg::norm_step(q2e_pkg::norm_step(q2e_pkg::norm_step(
			nrm_s6.vz, 2, 31), 1, 32), 1, q2e_pkg::NORM_BIT);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prep_s5 <= prep_c;
			nrm_s6  <= n1_c;
			nrm_s7  <= n2_c;
		end
	end

	// CORDIC vectoring, one iteration a stage for each of the three angles.
	for (genvar i = 0; i < NC; i++) begin : g_cord
		q2e_pkg::item_t nxt;
		if (i == 0) begin : g_first
			assign cord_in[i] = nrm_s7;
		end else begin : g_next
			assign cord_in[i] = cord_s8[i-1];
		end
		always_comb begin
			nxt    = cord_in[i];
			nxt.vx = q2e_pkg::cordic_step(cord_in[i].vx, i);
			nxt.vy = q2e_pkg::cordic_step(cord_in[i].vy, i);
			nxt.vz = q2e_pkg::cordic_step(cord_in[i].vz, i);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				cord_s8[i] <= nxt;
			end
		end
	end

	// Rounding, the doubled fallback angle and the clamps.
	always_comb begin
		fin    = cord_s8[NC-1];
		ax_acc = fin.vx.zero ? '0 : fin.vx.acc;
		ay_acc = fin.vy.zero ? '0 : fin.vy.acc;
		az_acc = fin.vz.zero ? '0 : fin.vz.acc;
		if (fin.dx) begin
			ax_acc = ax_acc << 1;
		end
		ox = q2e_pkg::to16(ax_acc);
		ty = q2e_pkg::to16(ay_acc);
		if (fin.sat) begin
			oy = fin.s_pos ? q2e_pkg::QUARTER : -q2e_pkg::QUARTER;
		end else if (ty > q2e_pkg::QUARTER) begin
			oy = q2e_pkg::QUARTER;
		end else if (ty < -q2e_pkg::QUARTER) begin
			oy = -q2e_pkg::QUARTER;
		end else begin
			oy = ty;
		end
		oz = fin.dz ? '0 : q2e_pkg::to16(az_acc);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= {oz, oy, ox};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			sqr_vld_s4  <= '0;
			vld_s5      <= 1'b0;
			vld_s6      <= 1'b0;
			vld_s7      <= 1'b0;
			cord_vld_s8 <= '0;
			res_vld_s9  <= 1'b0;
		end else if (en) begin
			vld_s1      <= s_axis_tvalid;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			sqr_vld_s4  <= {sqr_vld_s4[NS-2:0], vld_s3};
			vld_s5      <= sqr_vld_s4[NS-1];
			vld_s6      <= vld_s5;
			vld_s7      <= vld_s6;
			cord_vld_s8 <= {cord_vld_s8[NC-2:0], vld_s7};
			res_vld_s9  <= cord_vld_s8[NC-1];
		end
	end

endmodule

// File: tb/q2e_checker.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: checker
// Watches the input, output and register channels, predicts the three angles
// of every accepted quaternion and compares them with the results in order.
// ----------------------------------------------------------------------------
module q2e_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [47:0] m_axis_tdata,
	output int          fail_count,
	output int          pending_angles
);

	typedef struct packed {
		logic [15:0] ang_z;
		logic [15:0] ang_y;
		logic [15:0] ang_x;
	} angles_t;

	angles_t     angle_queue[$];
	logic [15:0] threshold;

	function automatic longint magnitude(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// atan2(y, x) as a 32-bit binary angle, 2^31 being pi.
	function automatic logic [31:0] vector_angle(longint vx, longint vy);
		logic [31:0] acc;
		longint      xs;
		longint      ys;
		acc = '0;
		if (vx == 0 && vy == 0)
			return '0;
		if (vx < 0) begin
			vx  = -vx;
			vy  = -vy;
			acc = q2e_pkg::ACC_PI;
		end
		while (magnitude(vx) < (64'sd1 <<< 33) && magnitude(vy) < (64'sd1 <<< 33)) begin
			vx = vx * 2;
			vy = vy * 2;
		end
		for (int i = 0; i < q2e_pkg::CORDIC_STAGES && i < q2e_pkg::TABLE_LEN; i++) begin
			xs = vx >>> i;
			ys = vy >>> i;
			if (vy >= 0) begin
				vx  = vx + ys;
				vy  = vy - xs;
				acc = acc + q2e_pkg::ATAN_TAB[i];
			end else begin
				vx  = vx - ys;
				vy  = vy + xs;
				acc = acc - q2e_pkg::ATAN_TAB[i];
			end
		end
		return acc;
	endfunction

	function automatic logic [15:0] round_angle(logic [31:0] acc);
		logic [31:0] s;
		s = acc + 32'h0000_8000;
		return s[31:16];
	endfunction

	function automatic longint unsigned root64(longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b   = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v   = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic bit below_threshold(longint a, longint b, logic [15:0] thr);
		return magnitude(a) <= longint'(thr) && magnitude(b) <= longint'(thr);
	endfunction

	function automatic angles_t predict_angles(logic [63:0] q, logic [15:0] thr);
		angles_t         r;
		longint          w, x, y, z, num, den, s, ay, one;
		longint unsigned c;
		logic [31:0]     acc;
		w   = longint'($signed(q[15:0]));
		x   = longint'($signed(q[31:16]));
		y   = longint'($signed(q[47:32]));
		z   = longint'($signed(q[63:48]));
		one = 64'sd1 <<< 28;

		num = 2 * (y * z + w * x);
		den = w * w - x * x - y * y + z * z;
		if (below_threshold(num, den, thr))
			acc = vector_angle(w, x) * 2;
		else
			acc = vector_angle(den, num);
		r.ang_x = round_angle(acc);

		s = -2 * (x * z - w * y);
		if (s > one)
			s = one;
		if (s < -one)
			s = -one;
		c = root64(longint'(one * one) - s * s);
		if (c == 0) begin
			ay = (s > 0) ? 16384 : ((s < 0) ? -16384 : 0);
		end else begin
			ay = longint'($signed(round_angle(vector_angle(longint'(c), s))));
			if (ay > 16384)
				ay = 16384;
			if (ay < -16384)
				ay = -16384;
		end
		r.ang_y = ay[15:0];

		num = 2 * (x * y + w * z);
		den = w * w + x * x - y * y - z * z;
		if (below_threshold(num, den, thr))
			r.ang_z = '0;
		else
			r.ang_z = round_angle(vector_angle(den, num));
		return r;
	endfunction

	assign pending_angles = angle_queue.size();

	always @(posedge clk or negedge arst_n) begin
		angles_t want;
		angles_t got;
		if (!arst_n) begin
			threshold <= q2e_pkg::THR_RESET;
			fail_count = 0;
			angle_queue.delete();
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				angle_queue.push_back(predict_angles(s_axis_tdata, threshold));
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (angle_queue.size() == 0) begin
					$error("unexpected result %h", m_axis_tdata);
					fail_count++;
				end else begin
					want = angle_queue.pop_front();
					if (got.ang_x !== want.ang_x) begin
						$error("angle_about_x expected %0d actual %0d",
							$signed(want.ang_x), $signed(got.ang_x));
						fail_count++;
					end
					if (got.ang_y !== want.ang_y) begin
						$error("angle_about_y expected %0d actual %0d",
							$signed(want.ang_y), $signed(got.ang_y));
						fail_count++;
					end
					if (got.ang_z !== want.ang_z) begin
						$error("angle_about_z expected %0d actual %0d",
							$signed(want.ang_z), $signed(got.ang_z));
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				threshold <= cfg_data;
		end
	end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: testbench
// Drives directed and random quaternions in bursts through several threshold
// settings, stalls the result side on its own pattern and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

	localparam int LATENCY   = 32;
	localparam int IDLE_MAX  = 5000;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;
	int          fail_count;
	int          pending_angles;
	int          quiet_cycles;
	bit          long_hold;
	bit          hold_done;

	quaternion_to_euler_angles_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	q2e_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.fail_count     (fail_count),
		.pending_angles (pending_angles)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Receiver: a stall pattern of its own, plus one long hold on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (long_hold) begin
			m_axis_tready <= 1'b0;
		end else begin
			case ($urandom_range(3))
				0: m_axis_tready <= 1'b0;
				default: m_axis_tready <= 1'b1;
			endcase
		end
	end

	initial begin
		long_hold = 1'b0;
		hold_done = 1'b0;
		wait (arst_n);
		repeat (400) @(posedge clk);
		long_hold = 1'b1;
		repeat (200) @(posedge clk);
		long_hold = 1'b0;
		hold_done = 1'b1;
	end

	// Watchdog: cycles with no transfer on any channel.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > IDLE_MAX) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	function automatic logic [15:0] random_component();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'sd16384;
			2: return -16'sd16384;
			3: return 16'($urandom_range(65535));
			4: return 16'($signed(7'($urandom)));
			default: return 16'($signed(17'($urandom_range(32768)) - 17'sd16384));
		endcase
	endfunction

	task automatic send_quat(input logic [15:0] w, x, y, z);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {z, y, x, w};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		// Random gap after a transfer, about one in four.
		if ($urandom_range(3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(6)) @(posedge clk);
		end
	endtask

	task automatic drain_pipeline();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_angles != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(input int count);
		logic [15:0] w, x, y, z;
		int          h;
		for (int n = 0; n < count; n++) begin
			w = random_component();
			x = random_component();
			y = random_component();
			z = random_component();
			h = $urandom_range(7);
			// Near gimbal lock and near-degenerate shapes.
			if (h == 0) begin
				x = '0;
				z = '0;
				y = 16'($urandom_range(20));
			end else if (h == 1) begin
				y = w;
				z = x;
			end else if (h == 2) begin
				y = -w;
				z = -x;
			end
			send_quat(w, x, y, z);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero, axes, extremes, gimbal lock, negative x axis.
		send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
		send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0);
		send_quat(-16'sd16384, 16'sd0, 16'sd0, 16'sd0);
		send_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd0);
		send_quat(16'sd0, 16'sd0, 16'sd16384, 16'sd0);
		send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd16384);
		send_quat(16'sd11585, 16'sd0, 16'sd11585, 16'sd0);
		send_quat(16'sd11585, 16'sd0, -16'sd11585, 16'sd0);
		send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
		send_quat(16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192);
		send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_quat(16'h8000, 16'sd0, 16'sd0, 16'sd0);
		send_quat(16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF);
		send_quat(16'sd0, 16'sd11585, 16'sd0, 16'sd11585);
		send_quat(16'sd3, 16'sd1, 16'sd0, 16'sd0);
		send_quat(-16'sd1, 16'sd0, 16'sd0, 16'sd0);
		send_quat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		drain_pipeline();

		write_threshold(16'd0);
		send_quat(16'sd3, 16'sd1, 16'sd0, 16'sd0);
		send_quat(16'sd0, 16'sd11585, 16'sd0, 16'sd11585);
		run_random(300);
		drain_pipeline();

		write_threshold(16'hFFFF);
		send_quat(16'sd100, 16'sd50, 16'sd0, 16'sd0);
		run_random(300);
		drain_pipeline();

		write_threshold(16'($urandom_range(65535)));
		run_random(300);
		drain_pipeline();

		write_threshold(16'd32);
		run_random(300);
		while (!hold_done)
			send_quat(random_component(), random_component(),
				random_component(), random_component());
		drain_pipeline();

		if (fail_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

// File: files.f
hdl/q2e_pkg.sv
hdl/quaternion_to_euler_angles_top.sv
tb/q2e_checker.sv
tb/testbench.sv
